### sv/chm_pkg.sv
// Package with transaction types, sequencer states and constants of the hash map lookup.
package chm_pkg;

  localparam int ACC_W       = 40;
  localparam int HEAD_BASE   = 4;
  localparam int LEN_MIN     = 3;
  localparam int ENTRY_WORDS = 3;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [9:0]         word_index;
    logic [63:0]        word_data;
    logic signed [31:0] hash;
    logic [63:0]        lookup_key;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        found;
    logic        table_ok;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN,
    ST_NE,
    ST_ND,
    ST_NB,
    ST_CNT,
    ST_SPAN,
    ST_LCHK,
    ST_EBASE,
    ST_HEAD,
    ST_LINK,
    ST_MUL3,
    ST_ADDR,
    ST_KEY,
    ST_VAL,
    ST_DONE
  } state_t;

endpackage

### sv/chained_hash_map_lookup_top.sv
// Top level of the hash map lookup: table memory, shared adder and lookup sequencer.
//
// Usage: one command channel (start, busy, in_data) and one result channel
// (out_strobe, out_data). A transaction is taken at a clock edge with start high
// and busy low. A write transaction (func 0) stores word_data at word_index and
// gives no result; an index at or above MEM_WORDS is dropped. A lookup transaction
// (func 1) reads the four header words and checks them with the shared adder; if
// they hold, it reads the bucket head and walks the chain, and for each entry it
// takes the link, triples it, forms the entry address and compares the key, then
// reads the value on a match or ends the walk. These steps run one after another on
// the single memory read port and the single shared adder. Busy stays high through
// the result cycle and falls in the cycle after, when the next transaction can be
// taken. The result is shown for exactly one cycle with out_strobe high; the receiver
// cannot stall it. Reset returns the sequencer to idle and leaves the table memory
// as it is; words read before being written are undefined. No lookup overlaps another.
module chained_hash_map_lookup_top #(
  parameter int MEM_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  chm_pkg::in_item_t  in_data,
  output logic              out_strobe,
  output chm_pkg::out_item_t out_data
);
  import chm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int SW = $clog2(MEM_WORDS + 1);
  localparam logic signed [ACC_W-1:0] MEM_LIM = ACC_W'(MEM_WORDS);

  logic [63:0] mem [MEM_WORDS];
  logic [63:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic mem_we;

  state_t state_r, state_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [63:0] key_r, key_nxt;
  logic signed [31:0] len_r, len_nxt;
  logic signed [31:0] ne_r, ne_nxt;
  logic signed [31:0] nd_r, nd_nxt;
  logic signed [31:0] nb_r, nb_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic signed [31:0] entry_r, entry_nxt;
  logic signed [ACC_W-1:0] count_r, count_nxt;
  logic signed [ACC_W-1:0] t_r, t_nxt;
  logic signed [ACC_W-1:0] ebase_r, ebase_nxt;
  logic signed [ACC_W-1:0] base_r, base_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic bad_r, bad_nxt;
  out_item_t res_r, res_nxt;

  logic signed [ACC_W-1:0] op_a, op_b, sum;
  logic cin;
  logic d_small;
  logic signed [31:0] d_val;
  logic signed [ACC_W-1:0] d_val_x, nb_x, entry_x, len_x, steps_x;

  assign d_small = (rd_data_r[31:0] == 32'h0);
  assign d_val   = signed'(rd_data_r[63:32]);
  assign d_val_x = {{(ACC_W-32){d_val[31]}}, d_val};
  assign nb_x    = {{(ACC_W-32){nb_r[31]}}, nb_r};
  assign entry_x = {{(ACC_W-32){entry_r[31]}}, entry_r};
  assign len_x   = {{(ACC_W-32){len_r[31]}}, len_r};
  assign steps_x = signed'(ACC_W'(steps_r));
  assign wr_addr = AW'(in_data.word_index);

  assign sum = op_a + op_b + {{(ACC_W-1){1'b0}}, cin};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_data.word_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    hash_r  <= hash_nxt;
    key_r   <= key_nxt;
    len_r   <= len_nxt;
    ne_r    <= ne_nxt;
    nd_r    <= nd_nxt;
    nb_r    <= nb_nxt;
    mask_r  <= mask_nxt;
    entry_r <= entry_nxt;
    count_r <= count_nxt;
    t_r     <= t_nxt;
    ebase_r <= ebase_nxt;
    base_r  <= base_nxt;
    steps_r <= steps_nxt;
    bad_r   <= bad_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    hash_nxt  = hash_r;
    key_nxt   = key_r;
    len_nxt   = len_r;
    ne_nxt    = ne_r;
    nd_nxt    = nd_r;
    nb_nxt    = nb_r;
    mask_nxt  = mask_r;
    entry_nxt = entry_r;
    count_nxt = count_r;
    t_nxt     = t_r;
    ebase_nxt = ebase_r;
    base_nxt  = base_r;
    steps_nxt = steps_r;
    bad_nxt   = bad_r;
    res_nxt   = res_r;
    op_a      = '0;
    op_b      = '0;
    cin       = 1'b0;
    rd_addr   = '0;
    mem_we    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_data.func == FUNC_LOOKUP) begin
            hash_nxt  = in_data.hash;
            key_nxt   = in_data.lookup_key;
            res_nxt   = '0;
            bad_nxt   = 1'b0;
            rd_addr   = AW'(0);
            state_nxt = ST_LEN;
          end else begin
            mem_we = (32'(in_data.word_index) < MEM_WORDS);
          end
        end
      end
      ST_LEN: begin
        len_nxt = d_val;
        if (!d_small || d_val < 32'sd3) begin
          bad_nxt = 1'b1;
        end
        rd_addr   = AW'(1);
        state_nxt = ST_NE;
      end
      ST_NE: begin
        ne_nxt = d_val;
        if (!d_small || d_val < 0) begin
          bad_nxt = 1'b1;
        end
        rd_addr   = AW'(2);
        state_nxt = ST_ND;
      end
      ST_ND: begin
        nd_nxt = d_val;
        if (!d_small || d_val < 0) begin
          bad_nxt = 1'b1;
        end
        rd_addr   = AW'(3);
        state_nxt = ST_NB;
      end
      ST_NB: begin
        nb_nxt   = d_val;
        op_a     = d_val_x;
        op_b     = '1;
        mask_nxt = sum[31:0];
        if (!d_small || d_val <= 0 || (rd_data_r[63:32] & sum[31:0]) != 32'h0) begin
          bad_nxt = 1'b1;
        end
        state_nxt = ST_CNT;
      end
      ST_CNT: begin
        op_a      = {{(ACC_W-32){ne_r[31]}}, ne_r};
        op_b      = {{(ACC_W-32){nd_r[31]}}, nd_r};
        count_nxt = sum;
        if (sum > {nb_x[ACC_W-2:0], 1'b0}) begin
          bad_nxt = 1'b1;
        end
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        op_a      = {nb_x[ACC_W-4:0], 3'b000};
        op_b      = ~nb_x;
        cin       = 1'b1;
        t_nxt     = sum;
        state_nxt = ST_LCHK;
      end
      ST_LCHK: begin
        op_a = t_r;
        op_b = ACC_W'(LEN_MIN);
        if (len_x < sum) begin
          bad_nxt = 1'b1;
        end
        state_nxt = ST_EBASE;
      end
      ST_EBASE: begin
        op_a      = nb_x;
        op_b      = ACC_W'(HEAD_BASE);
        ebase_nxt = sum;
        state_nxt = bad_r ? ST_DONE : ST_HEAD;
      end
      ST_HEAD: begin
        op_a             = ACC_W'(HEAD_BASE);
        op_b             = {{(ACC_W-32){1'b0}}, hash_r & mask_r};
        res_nxt.table_ok = 1'b1;
        steps_nxt        = '0;
        rd_addr          = sum[AW-1:0];
        state_nxt        = (sum >= MEM_LIM) ? ST_DONE : ST_LINK;
      end
      ST_LINK: begin
        entry_nxt = d_val;
        if (!d_small || d_val < 0 || d_val_x >= count_r || steps_x >= count_r ||
            steps_x >= MEM_LIM) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL3;
        end
      end
      ST_MUL3: begin
        op_a      = {entry_x[ACC_W-2:0], 1'b0};
        op_b      = entry_x;
        t_nxt     = sum;
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        op_a      = ebase_r;
        op_b      = t_r;
        base_nxt  = sum;
        rd_addr   = sum[AW-1:0];
        state_nxt = (sum >= MEM_LIM) ? ST_DONE : ST_KEY;
      end
      ST_KEY: begin
        op_a    = base_r;
        rd_addr = sum[AW-1:0];
        if (rd_data_r == key_r) begin
          op_b      = ACC_W'(1);
          state_nxt = (sum >= MEM_LIM) ? ST_DONE : ST_VAL;
        end else begin
          op_b      = ACC_W'(ENTRY_WORDS - 1);
          steps_nxt = SW'(steps_r + 1'b1);
          state_nxt = (sum >= MEM_LIM) ? ST_DONE : ST_LINK;
        end
      end
      ST_VAL: begin
        res_nxt.value = rd_data_r;
        res_nxt.found = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_DONE);
  assign out_data   = res_r;

endmodule

### tb/tb_chained_hash_map_lookup_top.sv
// Testbench of the hash map lookup: table image writes and key lookups against a chain-walk predictor.
`timescale 1ns / 100ps

module tb_chained_hash_map_lookup_top;
  import chm_pkg::*;

  localparam int MEM_WORDS   = 1024;
  localparam int ITEM_TARGET = 1650;

  typedef logic [63:0] word_img_t [0:MEM_WORDS-1];

  logic      clk;
  logic      rst_n;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_data = '0;
  logic      out_strobe;
  out_item_t out_data;

  in_item_t             pending_q[$];
  bit                   drain_q[$];
  out_item_t            lookup_results_due[$];
  word_img_t            table_img;
  word_img_t            plan_img;
  logic [MEM_WORDS-1:0] plan_known;
  longint               fill_span;
  longint               cycle_budget;
  longint               cycle_limit = 64'd100_000_000;
  longint               cycles = 0;
  int                   errors = 0;
  int                   issued = 0;
  bit                   took = 1'b0;
  bit                   drain_next;
  bit                   paused_once;
  logic [63:0]          ent_key [0:63];
  int                   ent_bkt [0:63];

  chained_hash_map_lookup_top #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [63:0] smallw(longint v);
    return {v[31:0], 32'h0};
  endfunction

  function automatic out_item_t chain_lookup(input word_img_t img,
                                             input logic [MEM_WORDS-1:0] known,
                                             input in_item_t it, output int miss,
                                             output int steps);
    out_item_t   r;
    longint      len, ne, nd, nb, cap, count, entry, lim, base, head;
    logic [31:0] bmask;
    logic [63:0] w;
    r = '0;
    miss = -1;
    steps = 0;
    for (int i = 0; i < HEAD_BASE; i++) begin
      if (!known[i]) begin
        miss = i;
        return r;
      end
    end
    if (img[0][31:0] != 0 || img[1][31:0] != 0 || img[2][31:0] != 0 || img[3][31:0] != 0)
      return r;
    len = longint'($signed(img[0][63:32]));
    ne  = longint'($signed(img[1][63:32]));
    nd  = longint'($signed(img[2][63:32]));
    nb  = longint'($signed(img[3][63:32]));
    if (len < LEN_MIN) return r;
    if (nb <= 0 || (nb & (nb - 1)) != 0) return r;
    cap = 2 * nb;
    if (ne < 0 || nd < 0 || ne + nd > cap) return r;
    if (len < 3 + nb + ENTRY_WORDS * cap) return r;
    r.table_ok = 1'b1;
    count = ne + nd;
    bmask = 32'(nb - 1);
    head = HEAD_BASE + longint'({32'h0, it.hash & bmask});
    if (head >= MEM_WORDS) return r;
    if (!known[head]) begin
      miss = int'(head);
      return r;
    end
    w = img[head];
    entry = (w[31:0] == 0) ? longint'($signed(w[63:32])) : -1;
    lim = (count > MEM_WORDS) ? MEM_WORDS : count;
    while (steps < lim && entry >= 0 && entry < count) begin
      base = HEAD_BASE + nb + entry * ENTRY_WORDS;
      steps++;
      if (base >= MEM_WORDS) return r;
      if (!known[base]) begin
        miss = int'(base);
        return r;
      end
      if (img[base] == it.lookup_key) begin
        if (base + 1 >= MEM_WORDS) return r;
        if (!known[base + 1]) begin
          miss = int'(base + 1);
          return r;
        end
        r.value = img[base + 1];
        r.found = 1'b1;
        return r;
      end
      if (base + 2 >= MEM_WORDS) return r;
      if (!known[base + 2]) begin
        miss = int'(base + 2);
        return r;
      end
      w = img[base + 2];
      entry = (w[31:0] == 0) ? longint'($signed(w[63:32])) : -1;
    end
    return r;
  endfunction

  function automatic logic [63:0] fill_word();
    if ($urandom_range(0, 2) != 0)
      return smallw(longint'($urandom_range(0, 32'(fill_span + 1))) - 1);
    return {$urandom, $urandom};
  endfunction

  task automatic queue_item(in_item_t it, int cost);
    pending_q.push_back(it);
    drain_q.push_back(drain_next);
    drain_next = 1'b0;
    cycle_budget += cost + 4;
  endtask

  task automatic put_word(int idx, logic [63:0] data);
    in_item_t it;
    it.func = FUNC_WRITE;
    it.word_index = idx[9:0];
    it.word_data = data;
    it.hash = $urandom;
    it.lookup_key = {$urandom, $urandom};
    plan_img[idx] = data;
    plan_known[idx] = 1'b1;
    queue_item(it, 2);
  endtask

  // fill every word the walk would touch before it is ever read
  task automatic ask_key(logic [31:0] h, logic [63:0] key);
    in_item_t it;
    int       miss, steps;
    it.func = FUNC_LOOKUP;
    it.word_index = 10'($urandom);
    it.word_data = {$urandom, $urandom};
    it.hash = h;
    it.lookup_key = key;
    void'(chain_lookup(plan_img, plan_known, it, miss, steps));
    while (miss >= 0) begin
      put_word(miss, fill_word());
      void'(chain_lookup(plan_img, plan_known, it, miss, steps));
    end
    queue_item(it, 16 + 4 * steps);
  endtask

  task automatic lay_table();
    int          nb, cap, cnt, nd, min_len, e, b;
    int          first [0:15];
    int          last [0:15];
    logic [63:0] chain [0:31];
    nb = 1 << $urandom_range(0, 4);
    cap = 2 * nb;
    cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap);
    nd = ($urandom_range(0, 2) == 0) ? $urandom_range(0, cnt) : 0;
    min_len = 3 + nb + 3 * cap;
    fill_span = cnt;
    put_word(0, smallw(min_len + $urandom_range(0, 2)));
    put_word(1, smallw(cnt - nd));
    put_word(2, smallw(nd));
    put_word(3, smallw(nb));
    for (b = 0; b < nb; b++) begin
      first[b] = -1;
      last[b] = -1;
    end
    for (e = 0; e < cnt; e++) begin
      b = $urandom_range(0, nb - 1);
      ent_bkt[e] = b;
      if (last[b] < 0) begin
        first[b] = e;
      end else begin
        chain[last[b]] = smallw(e);
      end
      last[b] = e;
    end
    for (b = 0; b < nb; b++) begin
      if (last[b] >= 0) begin
        case ($urandom_range(0, 9))
          0: chain[last[b]] = {$urandom, $urandom | 32'h1};
          1: chain[last[b]] = smallw(cnt + $urandom_range(0, 3));
          2: chain[last[b]] = smallw(first[b]);
          3: chain[last[b]] = smallw(-2 - longint'($urandom_range(0, 1000)));
          default: chain[last[b]] = smallw(-1);
        endcase
      end
      put_word(HEAD_BASE + b, (first[b] >= 0 || $urandom_range(0, 3) != 0) ?
               smallw(first[b]) : {$urandom, $urandom | 32'h1});
    end
    for (e = 0; e < cnt; e++) begin
      case ($urandom_range(0, 9))
        0, 1: ent_key[e] = smallw(longint'($urandom));
        2: ent_key[e] = (e > 0) ? ent_key[$urandom_range(0, e - 1)] : {64{1'b1}};
        default: ent_key[e] = {$urandom, $urandom};
      endcase
      put_word(HEAD_BASE + nb + ENTRY_WORDS * e, ent_key[e]);
      put_word(HEAD_BASE + nb + ENTRY_WORDS * e + 1, {$urandom, $urandom});
      put_word(HEAD_BASE + nb + ENTRY_WORDS * e + 2, chain[e]);
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: put_word(0, {$urandom, $urandom | 32'h1});
        1: put_word(0, smallw(min_len - 1 - $urandom_range(0, 5)));
        2: put_word(3, smallw(($urandom_range(0, 1) != 0) ? 0 : 3 * nb));
        3: put_word(1, smallw(-1 - longint'($urandom_range(0, 3))));
        4: put_word(2, smallw(cap - (cnt - nd) + 1));
        default: put_word(3, smallw(-longint'(nb)));
      endcase
    end
    repeat ($urandom_range(6, 16)) begin
      if ($urandom_range(0, 9) == 0)
        put_word(($urandom_range(0, 1) != 0) ? $urandom_range(HEAD_BASE, min_len) :
                 $urandom_range(0, MEM_WORDS - 1), {$urandom, $urandom});
      e = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
      case ($urandom_range(0, 4))
        0: ask_key($urandom, {$urandom, $urandom});
        1: ask_key($urandom, (cnt > 0) ? ent_key[e] : {$urandom, $urandom});
        default: ask_key(($urandom & ~32'(nb - 1)) | 32'((cnt > 0) ? ent_bkt[e] : 0),
                         (cnt > 0) ? ent_key[e] : {$urandom, $urandom});
      endcase
    end
  endtask

  // large bucket tables: heads and entries may sit beyond the memory
  task automatic lay_wide_table();
    int nb, cnt;
    nb = 1 << $urandom_range(8, 10);
    cnt = $urandom_range(nb, 2 * nb);
    fill_span = cnt;
    put_word(0, smallw(3 + 7 * nb + $urandom_range(0, 4)));
    put_word(1, smallw(cnt));
    put_word(2, smallw(0));
    put_word(3, smallw(nb));
    repeat ($urandom_range(3, 6)) ask_key($urandom, {$urandom, $urandom});
  endtask

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
    errors++;
  endtask

  initial begin
    plan_known = '0;
    fill_span = 2;
    drain_next = 1'b0;
    paused_once = 1'b0;
    cycle_budget = 0;
    put_word(0, smallw(10));
    put_word(1, smallw(2));
    put_word(2, smallw(0));
    put_word(3, smallw(1));
    put_word(4, smallw(0));
    put_word(5, {64{1'b1}});
    put_word(6, {64{1'b1}});
    put_word(7, smallw(1));
    put_word(8, 64'h0);
    put_word(9, 64'h0123_4567_89ab_cdef);
    put_word(10, smallw(2));
    put_word(1023, {64{1'b1}});
    ask_key(32'h8000_0000, {64{1'b1}});
    ask_key(32'h7fff_ffff, 64'h0);
    ask_key(32'hffff_ffff, 64'h5a5a_5a5a_a5a5_a5a5);
    put_word(10, 64'h0000_0001_0000_0001);
    ask_key(32'h0, 64'h5a5a_5a5a_a5a5_a5a5);
    put_word(10, smallw(1));
    ask_key(32'h0, 64'h5a5a_5a5a_a5a5_a5a5);
    put_word(1, smallw(-1));
    ask_key(32'h0, 64'h0);
    put_word(0, smallw(3 + 7 * 1024));
    put_word(1, smallw(0));
    put_word(3, smallw(1024));
    ask_key(32'd1023, 64'h0);
    while (pending_q.size() < ITEM_TARGET) begin
      if (!paused_once && pending_q.size() >= ITEM_TARGET / 2) begin
        drain_next = 1'b1;
        paused_once = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        lay_wide_table();
      end else begin
        lay_table();
      end
    end
    cycle_limit = 4 * cycle_budget + 20000;
    while (pending_q.size() != 0 || start || lookup_results_due.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (pending_q.size() != 0 &&
          !(drain_q[0] && (lookup_results_due.size() != 0 || busy)) &&
          ((issued >= 700 && issued < 1000) || $urandom_range(0, 99) >= 7)) begin
        in_data <= pending_q.pop_front();
        void'(drain_q.pop_front());
        issued <= issued + 1;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    int        miss, steps;
    took <= rst_n && start && !busy;
    if (rst_n && out_strobe) begin
      if (lookup_results_due.size() == 0) begin
        flag_mismatch("unexpected result", out_data.value, 64'h0);
      end else begin
        want = lookup_results_due.pop_front();
        if (out_data.value !== want.value) flag_mismatch("value", out_data.value, want.value);
        if (out_data.found !== want.found)
          flag_mismatch("found", 64'(out_data.found), 64'(want.found));
        if (out_data.table_ok !== want.table_ok)
          flag_mismatch("table_ok", 64'(out_data.table_ok), 64'(want.table_ok));
      end
    end
    if (rst_n && start && !busy) begin
      if (in_data.func == FUNC_WRITE) begin
        table_img[in_data.word_index] = in_data.word_data;
      end else begin
        lookup_results_due.push_back(
          chain_lookup(table_img, {MEM_WORDS{1'b1}}, in_data, miss, steps));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > cycle_limit) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule

### chained_hash_map_lookup_top.f
sv/chm_pkg.sv
sv/chained_hash_map_lookup_top.sv
tb/tb_chained_hash_map_lookup_top.sv
